/* rtl/core/asm_pkg.sv */
// ----------------------------------------------------------------------------
// Alive supervision monitor package
// Shared types, codes and widths for the alive supervision monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package asm_pkg;

  localparam int OP_W        = 3;
  localparam int TIME_W      = 64;
  localparam int COUNT_W     = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  // Iteration counts of the shared divide / multiply unit.
  localparam int DIV_STEPS = TIME_W;
  localparam int MUL_STEPS = COUNT_W;

  localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Event operation codes.
  localparam logic [OP_W-1:0] OP_CHECKPOINT      = 3'd0;
  localparam logic [OP_W-1:0] OP_ACTIVATE        = 3'd1;
  localparam logic [OP_W-1:0] OP_DEACTIVATE      = 3'd2;
  localparam logic [OP_W-1:0] OP_CRASH_RECOVERED = 3'd3;
  localparam logic [OP_W-1:0] OP_SYNC            = 3'd4;
  localparam logic [OP_W-1:0] OP_DATA_LOSS       = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_REFERENCE_CYCLE  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_INDICATIONS  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_INDICATIONS  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_CHECK_OFF    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_CHECK_OFF    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_FAILED_TOLERANCE = 3'd5;

  typedef enum logic [1:0] {
    ALIVE_DEACTIVATED = 2'd0,
    ALIVE_OK          = 2'd1,
    ALIVE_FAILED      = 2'd2,
    ALIVE_EXPIRED     = 2'd3
  } alive_state_t;

  typedef enum logic [1:0] {
    CAUSE_NONE      = 2'd0,
    CAUSE_DATA_LOSS = 2'd1,
    CAUSE_TOLERANCE = 2'd2,
    CAUSE_OVERFLOW  = 2'd3
  } expire_cause_t;

  // Outcome of the loop head that decides whether a passed cycle end is evaluated.
  typedef enum logic [1:0] {
    CHK_EXIT   = 2'd0,
    CHK_DIVIDE = 2'd1,
    CHK_SKIP   = 2'd2
  } check_outcome_t;

  typedef enum logic [3:0] {
    C_IDLE  = 4'd0,
    C_CHECK = 4'd1,
    C_DIV   = 4'd2,
    C_SKIP  = 4'd3,
    C_MUL   = 4'd4,
    C_EVAL  = 4'd5,
    C_OP    = 4'd6,
    C_DONE  = 4'd7
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic check;
    logic div_commit;
    logic skip;
    logic mul_commit;
    logic eval;
    logic op;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    check_outcome_t chk;
    logic           skip_mul;
    logic           arith_done;
    logic           out_free;
  } dp_status_t;

  typedef struct packed {
    logic div;
    logic mul;
  } arith_cmd_t;

endpackage

/* rtl/core/asm_arith.sv */
// ----------------------------------------------------------------------------
// Alive supervision divide / multiply unit
// Restoring divider (one quotient bit per cycle) and shift-add multiplier
// (one multiplier bit per cycle) sharing one set of working registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module asm_arith (
  input  logic                        clk,
  input  logic                        rst,
  input  asm_pkg::arith_cmd_t         cmd,
  input  logic [asm_pkg::TIME_W-1:0]  dividend,
  input  logic [asm_pkg::TIME_W-1:0]  divisor,
  input  logic [asm_pkg::COUNT_W-1:0] multiplier,
  input  logic [asm_pkg::TIME_W-1:0]  multiplicand,
  output logic                        done,
  output logic [asm_pkg::TIME_W-1:0]  quotient,
  output logic [asm_pkg::TIME_W-1:0]  remainder,
  output logic [asm_pkg::TIME_W-1:0]  product
);
  import asm_pkg::*;

  localparam int STEP_W = $clog2(DIV_STEPS + 1);

  logic              busy;
  logic              mul_mode;
  logic [STEP_W-1:0] steps;
  logic [TIME_W-1:0] acc;
  logic [TIME_W-1:0] work;
  logic [COUNT_W-1:0] mplier;

  logic [TIME_W:0]   rem_sh;
  logic [TIME_W:0]   rem_sub;
  logic              rem_ge;

  // The accumulator holds the partial remainder in divide mode and the
  // running product in multiply mode.
  assign rem_sh  = {acc, work[TIME_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  assign quotient  = work;
  assign remainder = acc;
  assign product   = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      mul_mode <= 1'b0;
      steps    <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.div) begin
        busy     <= 1'b1;
        mul_mode <= 1'b0;
        steps    <= STEP_W'(DIV_STEPS);
      end else if (cmd.mul) begin
        busy     <= 1'b1;
        mul_mode <= 1'b1;
        steps    <= STEP_W'(MUL_STEPS);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div) begin
      acc  <= '0;
      work <= dividend;
    end else if (cmd.mul) begin
      acc    <= '0;
      work   <= multiplicand;
      mplier <= multiplier;
    end else if (busy) begin
      if (mul_mode) begin
        if (mplier[0]) begin
          acc <= acc + work;
        end
        work   <= {work[TIME_W-2:0], 1'b0};
        mplier <= {1'b0, mplier[COUNT_W-1:1]};
      end else begin
        acc  <= rem_ge ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
        work <= {work[TIME_W-2:0], rem_ge};
      end
    end
  end

endmodule

/* rtl/core/asm_dp.sv */
// ----------------------------------------------------------------------------
// Alive supervision datapath
// Configuration, supervision state, cycle-end arithmetic and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module asm_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [asm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [asm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [asm_pkg::OP_W-1:0]        operation,
  input  logic [asm_pkg::TIME_W-1:0]      event_time,
  input  asm_pkg::dp_cmd_t                cmd,
  output asm_pkg::dp_status_t             stat,
  input  logic                            result_stall,
  output logic                            result_valid,
  output logic [1:0]                      status,
  output logic [asm_pkg::TIME_W-1:0]      status_time,
  output logic [1:0]                      expire_cause,
  output logic                            status_changed,
  output logic [asm_pkg::COUNT_W-1:0]     failed_count
);
  import asm_pkg::*;

  // Configuration.
  logic [TIME_W-1:0]  ref_cycle, ref_cycle_next;
  logic [COUNT_W-1:0] min_ind, min_ind_next;
  logic [COUNT_W-1:0] max_ind, max_ind_next;
  logic               min_off, min_off_next;
  logic               max_off, max_off_next;
  logic [COUNT_W-1:0] fail_tol, fail_tol_next;

  // Supervision state.
  alive_state_t       alive_state, alive_state_next;
  logic [TIME_W-1:0]  cycle_end, cycle_end_next;
  logic [COUNT_W-1:0] ind_count, ind_count_next;
  logic [COUNT_W-1:0] fail_cycles, fail_cycles_next;
  logic [TIME_W-1:0]  last_sync, last_sync_next;
  logic [TIME_W-1:0]  event_stamp, event_stamp_next;
  expire_cause_t      last_cause, last_cause_next;

  // Per-event working registers.
  logic [OP_W-1:0]    op_reg, op_reg_next;
  logic [TIME_W-1:0]  t_reg, t_reg_next;
  logic               changed, changed_next;
  logic               have_m, have_m_next;
  logic [TIME_W-1:0]  m_left, m_left_next;
  logic [TIME_W-1:0]  last_end, last_end_next;

  // Result register.
  logic               result_valid_next;
  logic [1:0]         status_next;
  logic [TIME_W-1:0]  status_time_next;
  logic [1:0]         expire_cause_next;
  logic               status_changed_next;
  logic [COUNT_W-1:0] failed_count_next;

  logic               active;
  logic               is_sync;
  logic               is_loss;
  logic               cyc_err;
  logic [TIME_W:0]    c_plus;
  logic [TIME_W:0]    t_plus;
  logic [TIME_W-1:0]  div_dividend;
  check_outcome_t     chk;

  logic               skip_full;
  logic               span_valid;
  logic               span_dec;
  logic [COUNT_W-1:0] span;
  logic               span_covers;
  logic               skip_mul;
  logic [COUNT_W-1:0] fc_adjusted;

  arith_cmd_t         arith_cmd;
  logic               arith_done;
  logic [TIME_W-1:0]  quotient;
  logic [TIME_W-1:0]  remainder;
  logic [TIME_W-1:0]  product;

  assign active  = (alive_state == ALIVE_OK) || (alive_state == ALIVE_FAILED);
  assign is_sync = (op_reg == OP_SYNC);
  assign is_loss = (op_reg == OP_DATA_LOSS);
  assign cyc_err = (!min_off && (ind_count < min_ind)) || (!max_off && (ind_count > max_ind));
  assign c_plus  = {1'b0, cycle_end} + {1'b0, ref_cycle};
  assign t_plus  = {1'b0, t_reg} + {1'b0, ref_cycle};

  // t - c - 1 for ordinary events, t - c for a sync.
  assign div_dividend = t_reg + ~cycle_end + {{(TIME_W-1){1'b0}}, is_sync};

  always_comb begin
    chk = CHK_EXIT;
    if (!is_loss && active) begin
      if (have_m) begin
        if (m_left != '0) begin
          chk = CHK_SKIP;
        end
      end else if (cycle_end < t_reg) begin
        chk = CHK_DIVIDE;
      end else if ((cycle_end == t_reg) && is_sync) begin
        chk = CHK_SKIP;
      end
    end
  end

  // Identical empty cycles are skipped in one go as far as the failed count allows.
  always_comb begin
    skip_full  = 1'b0;
    span_valid = 1'b0;
    span_dec   = 1'b0;
    span       = '0;
    if ((ind_count == '0) && (m_left != '0)) begin
      if ((alive_state == ALIVE_OK) && !cyc_err) begin
        skip_full = 1'b1;
      end else if ((alive_state == ALIVE_FAILED) && !cyc_err && (fail_cycles > COUNT_W'(1))) begin
        span_valid = 1'b1;
        span_dec   = 1'b1;
        span       = fail_cycles - COUNT_W'(1);
      end else if ((alive_state == ALIVE_FAILED) && cyc_err && (fail_tol > fail_cycles)) begin
        span_valid = 1'b1;
        span       = fail_tol - fail_cycles;
      end
    end
  end

  assign span_covers = {{(TIME_W-COUNT_W){1'b0}}, span} >= m_left;
  assign skip_mul    = span_valid && !span_covers;
  assign fc_adjusted = span_dec ? (fail_cycles - m_left[COUNT_W-1:0])
                                : (fail_cycles + m_left[COUNT_W-1:0]);

  assign arith_cmd.div = cmd.check && (chk == CHK_DIVIDE);
  assign arith_cmd.mul = cmd.skip && skip_mul;

  asm_arith u_arith (
    .clk          (clk),
    .rst          (rst),
    .cmd          (arith_cmd),
    .dividend     (div_dividend),
    .divisor      (ref_cycle),
    .multiplier   (span),
    .multiplicand (ref_cycle),
    .done         (arith_done),
    .quotient     (quotient),
    .remainder    (remainder),
    .product      (product)
  );

  assign stat.chk        = chk;
  assign stat.skip_mul   = skip_mul;
  assign stat.arith_done = arith_done;
  assign stat.out_free   = !result_valid || !result_stall;

  always_comb begin
    logic          nc;
    logic          act_req;
    logic          exp_req;
    expire_cause_t exp_cause;

    nc        = 1'b0;
    act_req   = 1'b0;
    exp_req   = 1'b0;
    exp_cause = CAUSE_NONE;

    ref_cycle_next      = ref_cycle;
    min_ind_next        = min_ind;
    max_ind_next        = max_ind;
    min_off_next        = min_off;
    max_off_next        = max_off;
    fail_tol_next       = fail_tol;
    alive_state_next    = alive_state;
    cycle_end_next      = cycle_end;
    ind_count_next      = ind_count;
    fail_cycles_next    = fail_cycles;
    last_sync_next      = last_sync;
    event_stamp_next    = event_stamp;
    last_cause_next     = last_cause;
    op_reg_next         = op_reg;
    t_reg_next          = t_reg;
    changed_next        = changed;
    have_m_next         = have_m;
    m_left_next         = m_left;
    last_end_next       = last_end;
    result_valid_next   = result_valid;
    status_next         = status;
    status_time_next    = status_time;
    expire_cause_next   = expire_cause;
    status_changed_next = status_changed;
    failed_count_next   = failed_count;

    if (cmd.load) begin
      op_reg_next  = operation;
      t_reg_next   = event_time;
      changed_next = 1'b0;
      have_m_next  = 1'b0;
    end

    if (cmd.check && (chk == CHK_SKIP)) begin
      if (have_m) begin
        m_left_next = m_left - TIME_W'(1);
      end else begin
        m_left_next = '0;
        have_m_next = 1'b1;
      end
    end

    // m_left counts the further cycle ends before the event time; last_end is
    // the last of them.
    if (cmd.div_commit) begin
      m_left_next   = quotient;
      last_end_next = t_reg + ~remainder + {{(TIME_W-1){1'b0}}, is_sync};
      have_m_next   = 1'b1;
    end

    if (cmd.skip) begin
      if (skip_full) begin
        cycle_end_next = last_end;
        m_left_next    = '0;
      end else if (span_valid) begin
        if (span_covers) begin
          cycle_end_next   = last_end;
          m_left_next      = '0;
          fail_cycles_next = fc_adjusted;
        end else begin
          fail_cycles_next = span_dec ? COUNT_W'(1) : fail_tol;
          m_left_next      = m_left - {{(TIME_W-COUNT_W){1'b0}}, span};
        end
      end
    end

    if (cmd.mul_commit) begin
      cycle_end_next = cycle_end + product;
    end

    if (cmd.eval) begin
      event_stamp_next = cycle_end;
      case (alive_state)
        ALIVE_OK: begin
          if (cyc_err) begin
            if (fail_cycles < fail_tol) begin
              alive_state_next = ALIVE_FAILED;
              fail_cycles_next = fail_cycles + COUNT_W'(1);
              changed_next     = 1'b1;
              nc               = 1'b1;
            end else begin
              exp_req   = 1'b1;
              exp_cause = CAUSE_TOLERANCE;
            end
          end else begin
            nc = 1'b1;
          end
        end
        ALIVE_FAILED: begin
          if (cyc_err) begin
            if (fail_cycles == COUNT_MAX) begin
              exp_req   = 1'b1;
              exp_cause = CAUSE_OVERFLOW;
            end else if (fail_cycles < fail_tol) begin
              fail_cycles_next = fail_cycles + COUNT_W'(1);
              nc               = 1'b1;
            end else begin
              exp_req   = 1'b1;
              exp_cause = CAUSE_TOLERANCE;
            end
          end else begin
            if (fail_cycles <= COUNT_W'(1)) begin
              alive_state_next = ALIVE_OK;
              fail_cycles_next = '0;
              changed_next     = 1'b1;
            end else begin
              fail_cycles_next = fail_cycles - COUNT_W'(1);
            end
            nc = 1'b1;
          end
        end
        default: begin
        end
      endcase
      // Start of the next reference cycle.
      if (nc) begin
        if (c_plus[TIME_W]) begin
          event_stamp_next = TIME_MAX;
          exp_req          = 1'b1;
          exp_cause        = CAUSE_OVERFLOW;
        end else begin
          cycle_end_next = c_plus[TIME_W-1:0];
          ind_count_next = '0;
        end
      end
    end

    if (cmd.op) begin
      case (op_reg)
        OP_CHECKPOINT: begin
          if (active) begin
            if (ind_count == COUNT_MAX) begin
              event_stamp_next = t_reg;
              exp_req          = 1'b1;
              exp_cause        = CAUSE_OVERFLOW;
            end else begin
              ind_count_next = ind_count + COUNT_W'(1);
            end
          end
        end
        OP_ACTIVATE: begin
          if (alive_state == ALIVE_DEACTIVATED) begin
            act_req = 1'b1;
          end
        end
        OP_DEACTIVATE: begin
          if (alive_state != ALIVE_DEACTIVATED) begin
            event_stamp_next = t_reg;
            alive_state_next = ALIVE_DEACTIVATED;
            fail_cycles_next = '0;
            ind_count_next   = '0;
            cycle_end_next   = TIME_MAX;
            changed_next     = 1'b1;
          end
        end
        OP_CRASH_RECOVERED: begin
          alive_state_next = ALIVE_DEACTIVATED;
          fail_cycles_next = '0;
          ind_count_next   = '0;
          cycle_end_next   = TIME_MAX;
          changed_next     = 1'b1;
          act_req          = 1'b1;
        end
        OP_SYNC: begin
          last_sync_next = t_reg;
        end
        OP_DATA_LOSS: begin
          event_stamp_next = (t_reg == '0) ? last_sync : t_reg;
          if (alive_state != ALIVE_EXPIRED) begin
            exp_req   = 1'b1;
            exp_cause = CAUSE_DATA_LOSS;
          end
        end
        default: begin
        end
      endcase
      if (act_req) begin
        if (t_plus[TIME_W]) begin
          event_stamp_next = TIME_MAX;
          exp_req          = 1'b1;
          exp_cause        = CAUSE_OVERFLOW;
        end else begin
          cycle_end_next   = t_plus[TIME_W-1:0];
          event_stamp_next = t_reg;
          alive_state_next = ALIVE_OK;
          fail_cycles_next = '0;
          changed_next     = 1'b1;
        end
      end
    end

    if (exp_req) begin
      alive_state_next = ALIVE_EXPIRED;
      fail_cycles_next = fail_tol;
      ind_count_next   = '0;
      cycle_end_next   = TIME_MAX;
      last_cause_next  = exp_cause;
      changed_next     = 1'b1;
    end

    if (cfg_wen) begin
      unique case (cfg_index)
        REG_REFERENCE_CYCLE:  ref_cycle_next = (cfg_data == '0) ? TIME_W'(1) : cfg_data;
        REG_MIN_INDICATIONS:  min_ind_next   = cfg_data[COUNT_W-1:0];
        REG_MAX_INDICATIONS:  max_ind_next   = cfg_data[COUNT_W-1:0];
        REG_MIN_CHECK_OFF:    min_off_next   = cfg_data[0];
        REG_MAX_CHECK_OFF:    max_off_next   = cfg_data[0];
        REG_FAILED_TOLERANCE: fail_tol_next  = cfg_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end

    if (cmd.out_load) begin
      result_valid_next   = 1'b1;
      status_next         = alive_state;
      status_time_next    = event_stamp;
      expire_cause_next   = (alive_state == ALIVE_EXPIRED) ? last_cause : CAUSE_NONE;
      status_changed_next = changed;
      failed_count_next   = fail_cycles;
    end else if (result_valid && !result_stall) begin
      result_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_cycle    <= TIME_W'(1);
      min_ind      <= '0;
      max_ind      <= COUNT_MAX;
      min_off      <= 1'b0;
      max_off      <= 1'b0;
      fail_tol     <= '0;
      alive_state  <= ALIVE_DEACTIVATED;
      cycle_end    <= TIME_MAX;
      ind_count    <= '0;
      fail_cycles  <= '0;
      last_sync    <= '0;
      event_stamp  <= '0;
      last_cause   <= CAUSE_NONE;
      result_valid <= 1'b0;
    end else begin
      ref_cycle    <= ref_cycle_next;
      min_ind      <= min_ind_next;
      max_ind      <= max_ind_next;
      min_off      <= min_off_next;
      max_off      <= max_off_next;
      fail_tol     <= fail_tol_next;
      alive_state  <= alive_state_next;
      cycle_end    <= cycle_end_next;
      ind_count    <= ind_count_next;
      fail_cycles  <= fail_cycles_next;
      last_sync    <= last_sync_next;
      event_stamp  <= event_stamp_next;
      last_cause   <= last_cause_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op_reg         <= op_reg_next;
    t_reg          <= t_reg_next;
    changed        <= changed_next;
    have_m         <= have_m_next;
    m_left         <= m_left_next;
    last_end       <= last_end_next;
    status         <= status_next;
    status_time    <= status_time_next;
    expire_cause   <= expire_cause_next;
    status_changed <= status_changed_next;
    failed_count   <= failed_count_next;
  end

endmodule

/* rtl/core/asm_ctrl.sv */
// ----------------------------------------------------------------------------
// Alive supervision controller
// Sequences one event through the cycle-end loop and the event handling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module asm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  asm_pkg::dp_status_t stat,
  output asm_pkg::dp_cmd_t    cmd
);
  import asm_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_stall = 1'b1;
    unique case (state)
      C_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = C_CHECK;
        end
      end
      C_CHECK: begin
        cmd.check = 1'b1;
        case (stat.chk)
          CHK_DIVIDE: state_next = C_DIV;
          CHK_SKIP:   state_next = C_SKIP;
          default:    state_next = C_OP;
        endcase
      end
      C_DIV: begin
        if (stat.arith_done) begin
          cmd.div_commit = 1'b1;
          state_next     = C_SKIP;
        end
      end
      C_SKIP: begin
        cmd.skip   = 1'b1;
        state_next = stat.skip_mul ? C_MUL : C_EVAL;
      end
      C_MUL: begin
        if (stat.arith_done) begin
          cmd.mul_commit = 1'b1;
          state_next     = C_EVAL;
        end
      end
      C_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = C_CHECK;
      end
      C_OP: begin
        cmd.op     = 1'b1;
        state_next = C_DONE;
      end
      C_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = C_IDLE;
        end
      end
      default: begin
        state_next = C_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/alive_supervision_monitor_top.sv */
// ----------------------------------------------------------------------------
// Alive supervision monitor, top level
// Watchdog over time-ordered alive checkpoint events, one result per event.
// ----------------------------------------------------------------------------
// Usage:
// Events arrive on the item channel (operation, event_time) and each accepted
// transfer yields exactly one transfer on the result channel (status,
// status_time, expire_cause, status_changed, failed_count). Both channels use
// valid/stall; a transfer happens on a rising edge with valid high and stall low.
// The configuration registers are written through cfg_wen/cfg_index/cfg_data
// while no event is in flight.
// Event flow: an event with no passed reference cycle end goes through accept,
// loop check, event handling and result load. When cycle ends have passed, the
// first loop pass runs the 64-step divider to count them, and each loop pass
// goes through check, skip and evaluation, plus the 32-step multiplier when a
// partial run of empty cycles is skipped. A gap takes at most three loop
// passes and one multiply.
// The item side is stalled while an event is worked on; one finished result
// can wait in the output register while the next event is accepted.
// A stalled result holds its value until taken.
// Reset (synchronous, active high) restores the register defaults and the
// deactivated status, and empties the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alive_supervision_monitor_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [asm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [asm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic [asm_pkg::OP_W-1:0]        operation,
  input  logic [asm_pkg::TIME_W-1:0]      event_time,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [1:0]                      status,
  output logic [asm_pkg::TIME_W-1:0]      status_time,
  output logic [1:0]                      expire_cause,
  output logic                            status_changed,
  output logic [asm_pkg::COUNT_W-1:0]     failed_count
);
  import asm_pkg::*;

  // Command and status between the sequencer and the datapath.
  dp_cmd_t    cmd;
  dp_status_t stat;

  asm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  // The datapath holds configuration, supervision state, the shared
  // divide/multiply unit and the result register.
  asm_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wen        (cfg_wen),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .operation      (operation),
    .event_time     (event_time),
    .cmd            (cmd),
    .stat           (stat),
    .result_stall   (result_stall),
    .result_valid   (result_valid),
    .status         (status),
    .status_time    (status_time),
    .expire_cause   (expire_cause),
    .status_changed (status_changed),
    .failed_count   (failed_count)
  );

endmodule

/* rtl/core/asm_checker.sv */
// ----------------------------------------------------------------------------
// Alive supervision monitor checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module asm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            item_valid,
  input logic                            item_stall,
  input logic                            result_valid,
  input logic                            result_stall,
  input logic [1:0]                      status,
  input logic [asm_pkg::TIME_W-1:0]      status_time,
  input logic [1:0]                      expire_cause,
  input logic                            status_changed,
  input logic [asm_pkg::COUNT_W-1:0]     failed_count
);
  import asm_pkg::*;

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // An expire cause is reported exactly when the status is expired.
  a_cause_match: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((status == ALIVE_EXPIRED) == (expire_cause != CAUSE_NONE)))
    else $error("expire cause does not match status");

  // A deactivated monitor carries no failed cycles.
  a_deact_count: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (status == ALIVE_DEACTIVATED)) |-> (failed_count == '0))
    else $error("failed count nonzero while deactivated");

  // An accepted event keeps the item side stalled in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("item accepted while previous event in flight");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(status) &&
      $stable(status_time) && $stable(expire_cause) && $stable(status_changed) &&
      $stable(failed_count)))
    else $error("stalled result changed");

endmodule

bind alive_supervision_monitor_top asm_checker u_asm_checker (.*);
